>>> rtl/knn_squared_distance_search_core_macros.svh
// Assertion helpers for the search core.
`ifndef KNN_SQUARED_DISTANCE_SEARCH_CORE_MACROS_SVH
`define KNN_SQUARED_DISTANCE_SEARCH_CORE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define KNN_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define KNN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/knn_pkg.sv
package knn_pkg;

	// Fixed field widths
	localparam int ID_W       = 16;
	localparam int CMD_W      = 2;
	localparam int DIST_W     = 38;
	localparam int FC_W       = 7;
	localparam int NC_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Saturation ceiling of the running distance
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CAND  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd1;

	// Register reset values
	localparam logic [FC_W-1:0] FC_RESET = 7'd64;
	localparam logic [NC_W-1:0] NC_RESET = 5'd4;

	// Parameter defaults
	localparam int MAX_FEATURES_DEF  = 64;
	localparam int MAX_NEIGHBORS_DEF = 16;
	localparam int FEATURE_BITS_DEF  = 16;

	// Controls for the multiply-accumulate unit
	typedef struct packed {
		logic diff_en;
		logic sq_en;
		logic acc_en;
		logic clear;
	} mac_ctrl_t;

endpackage

>>> rtl/knn_mac.sv
module knn_mac #(
	parameter int FEATURE_BITS = knn_pkg::FEATURE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  knn_pkg::mac_ctrl_t               ctrl,
	input  logic signed [FEATURE_BITS-1:0]   query_value,
	input  logic signed [FEATURE_BITS-1:0]   cand_value,
	output logic [knn_pkg::DIST_W-1:0]       sum_sat
);
	import knn_pkg::*;

	localparam int MAG_W  = FEATURE_BITS + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;

	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        mag_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic [DIST_W-1:0]       run_q;
	logic [SUM_W-1:0]        sum;

	// Absolute feature difference
	always_comb begin
		diff = MAG_W'(query_value) - MAG_W'(cand_value);
		mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
	end

	// Difference stage, then square stage
	always_ff @(posedge clk) begin
		if (ctrl.diff_en) begin
			mag_s1 <= mag;
		end
		if (ctrl.sq_en) begin
			prod_s2 <= mag_s1 * mag_s1;
		end
	end

	// Saturating add onto the running distance
	always_comb begin
		sum     = SUM_W'(run_q) + SUM_W'(prod_s2);
		sum_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
	end

	// Hold, advance or drop the running distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctrl.acc_en) begin
			run_q <= ctrl.clear ? '0 : sum_sat;
		end
	end

endmodule

>>> rtl/knn_squared_distance_search_core.sv
// Channel  | Handshake              | Beat contents
// input    | in_valid / in_stall    | command, vector_id, feature_value
// output   | out_valid / out_stall  | neighbor_id, neighbor_distance, last_neighbor
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A query feature is written to the query memory. A candidate feature passes through
// query memory read, difference, square and accumulate via the one multiply-accumulate
// unit. A finished candidate that replaces a slot scans the filled slots, one slot per
// cycle through the single read port of the slot memory; emit reads and then loads each
// neighbor in turn, and a held beat waits on out_stall before the next one is read.
// Reset clears control state only; query and slot memories are not swept.
`include "knn_squared_distance_search_core_macros.svh"

module knn_squared_distance_search_core #(
	parameter int MAX_FEATURES  = knn_pkg::MAX_FEATURES_DEF,
	parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
	parameter int FEATURE_BITS  = knn_pkg::FEATURE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [knn_pkg::CMD_W-1:0]         command,
	input  logic [knn_pkg::ID_W-1:0]          vector_id,
	input  logic signed [FEATURE_BITS-1:0]    feature_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [knn_pkg::ID_W-1:0]          neighbor_id,
	output logic [knn_pkg::DIST_W-1:0]        neighbor_distance,
	output logic                              last_neighbor,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import knn_pkg::*;

	localparam int QA_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int PW   = $clog2(MAX_FEATURES + 1);
	localparam int SA_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int NW   = $clog2(MAX_NEIGHBORS + 1);
	localparam int FCW  = (PW > FC_W) ? PW : FC_W;
	localparam int KCW  = (NW > NC_W) ? NW : NC_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SUB     = 3'd1;
	localparam logic [2:0] ST_MUL     = 3'd2;
	localparam logic [2:0] ST_ACC     = 3'd3;
	localparam logic [2:0] ST_SCAN    = 3'd4;
	localparam logic [2:0] ST_EMIT_RD = 3'd5;
	localparam logic [2:0] ST_EMIT_WR = 3'd6;

	logic [2:0]        state_q;
	logic [FC_W-1:0]   fc_q;
	logic [NC_W-1:0]   nc_q;
	logic [ID_W-1:0]   qid_q;
	logic [PW-1:0]     pos_q;
	logic [NW-1:0]     fill_q;
	logic [DIST_W-1:0] max_q;
	logic              done_q;
	logic [NW-1:0]     issue_q;
	logic              vld_s1;
	logic              found_q;
	logic              out_valid_q;

	logic [ID_W-1:0]          cid_q;
	logic signed [FEATURE_BITS-1:0] fv_q;
	logic [DIST_W-1:0]        dist_q;
	logic [SA_W-1:0]          idx_s1;
	logic [SA_W-1:0]          found_idx_q;
	logic [DIST_W-1:0]        acc_max_q;
	logic [ID_W-1:0]          out_id_q;
	logic [DIST_W-1:0]        out_dist_q;
	logic                     out_last_q;

	// Memories and their read data
	logic signed [FEATURE_BITS-1:0] qmem [MAX_FEATURES];
	logic signed [FEATURE_BITS-1:0] q_rd_q;
	logic [DIST_W-1:0]              slot_dist_mem [MAX_NEIGHBORS];
	logic [ID_W-1:0]                slot_id_mem [MAX_NEIGHBORS];
	logic [DIST_W-1:0]              slot_rd_dist_q;
	logic [ID_W-1:0]                slot_rd_id_q;

	logic [FCW-1:0]    fc_ext;
	logic [KCW-1:0]    nc_ext;
	logic [PW-1:0]     n_eff;
	logic [NW-1:0]     k_eff;
	logic [PW-1:0]     pos_inc;
	logic              pos_done;
	logic              accept;
	logic              feat_item;
	logic              q_we;
	logic              q_re;
	logic              slot_re;
	logic              slot_we;
	logic [SA_W-1:0]   slot_waddr;
	logic [DIST_W-1:0] slot_wdist;
	logic [DIST_W-1:0] sum_sat;
	mac_ctrl_t         mac_ctrl;
	logic              fin;
	logic              append;
	logic              start_scan;
	logic              scan_end;
	logic              out_free;
	logic              emit_load;
	logic              emit_last;
	logic              emit_empty;

	// Effective feature and neighbor counts
	always_comb begin
		fc_ext = FCW'(fc_q);
		nc_ext = KCW'(nc_q);
		if (fc_ext == '0) begin
			n_eff = PW'(1);
		end else if (fc_ext > FCW'(MAX_FEATURES)) begin
			n_eff = PW'(MAX_FEATURES);
		end else begin
			n_eff = fc_ext[PW-1:0];
		end
		if (nc_ext == '0) begin
			k_eff = NW'(1);
		end else if (nc_ext > KCW'(MAX_NEIGHBORS)) begin
			k_eff = NW'(MAX_NEIGHBORS);
		end else begin
			k_eff = nc_ext[NW-1:0];
		end
	end

	// Sequencer strobes
	always_comb begin
		accept     = in_valid && (state_q == ST_IDLE);
		feat_item  = accept && ((command == CMD_QUERY) || (command == CMD_CAND));
		pos_inc    = pos_q + PW'(1);
		pos_done   = (pos_inc >= n_eff);
		q_we       = accept && (command == CMD_QUERY);
		q_re       = accept && (command == CMD_CAND);
		emit_empty = accept && (command == CMD_EMIT) && (fill_q == '0);

		fin        = (state_q == ST_ACC) && done_q && (cid_q != qid_q);
		append     = fin && (fill_q < k_eff);
		start_scan = fin && !append && (sum_sat < max_q);
		scan_end   = (state_q == ST_SCAN) && (issue_q == fill_q) && !vld_s1;

		out_free   = !out_valid_q || !out_stall;
		emit_load  = (state_q == ST_EMIT_WR) && out_free;
		emit_last  = ((issue_q + NW'(1)) == fill_q);

		slot_re    = ((state_q == ST_SCAN) && (issue_q < fill_q)) || (state_q == ST_EMIT_RD);
		slot_we    = append || scan_end;
		slot_waddr = append ? fill_q[SA_W-1:0] : found_idx_q;
		slot_wdist = append ? sum_sat : dist_q;

		mac_ctrl.diff_en = (state_q == ST_SUB);
		mac_ctrl.sq_en   = (state_q == ST_MUL);
		mac_ctrl.acc_en  = (state_q == ST_ACC) || (q_we && pos_done) || emit_empty ||
			(emit_load && emit_last);
		mac_ctrl.clear   = (state_q != ST_ACC) || done_q;
	end

	// Query memory: write on query beats, read on candidate beats
	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[pos_q[QA_W-1:0]] <= feature_value;
		end
		if (q_re) begin
			q_rd_q <= qmem[pos_q[QA_W-1:0]];
		end
	end

	// Slot memory: one write port, one read port at the scan counter
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_dist_mem[slot_waddr] <= slot_wdist;
			slot_id_mem[slot_waddr]   <= cid_q;
		end
		if (slot_re) begin
			slot_rd_dist_q <= slot_dist_mem[issue_q[SA_W-1:0]];
			slot_rd_id_q   <= slot_id_mem[issue_q[SA_W-1:0]];
		end
	end

	knn_mac #(
		.FEATURE_BITS(FEATURE_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mac_ctrl),
		.query_value(q_rd_q),
		.cand_value (fv_q),
		.sum_sat    (sum_sat)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fc_q        <= FC_RESET;
			nc_q        <= NC_RESET;
			qid_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			max_q       <= '0;
			done_q      <= 1'b0;
			issue_q     <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Register writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_FEATURE_COUNT:  fc_q <= cfg_data[FC_W-1:0];
					REG_NEIGHBOR_COUNT: nc_q <= cfg_data[NC_W-1:0];
					default: ;
				endcase
			end

			// Advance the shared feature position
			if (feat_item) begin
				pos_q  <= pos_done ? '0 : pos_inc;
				done_q <= pos_done;
			end
			if (q_we) begin
				qid_q <= vector_id;
			end

			// Drop a result once taken, load a new one on emit
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_re) begin
						state_q <= ST_SUB;
					end else if (accept && (command == CMD_EMIT)) begin
						issue_q <= '0;
						if (emit_empty) begin
							fill_q <= '0;
							max_q  <= '0;
							pos_q  <= '0;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_SUB: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (append) begin
						fill_q <= fill_q + NW'(1);
						if (sum_sat > max_q) begin
							max_q <= sum_sat;
						end
						state_q <= ST_IDLE;
					end else if (start_scan) begin
						issue_q <= '0;
						vld_s1  <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					vld_s1 <= slot_re;
					if (slot_re) begin
						issue_q <= issue_q + NW'(1);
					end
					if (vld_s1 && !found_q && (slot_rd_dist_q == max_q)) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						max_q   <= (acc_max_q > dist_q) ? acc_max_q : dist_q;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (emit_load) begin
						issue_q <= issue_q + NW'(1);
						if (emit_last) begin
							fill_q  <= '0;
							max_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (q_re) begin
			cid_q <= vector_id;
			fv_q  <= feature_value;
		end
		if (start_scan) begin
			dist_q    <= sum_sat;
			acc_max_q <= '0;
		end
		if (slot_re) begin
			idx_s1 <= issue_q[SA_W-1:0];
		end
		// First slot at the maximum is the one replaced; the rest feed the new maximum
		if ((state_q == ST_SCAN) && vld_s1) begin
			if (!found_q && (slot_rd_dist_q == max_q)) begin
				found_idx_q <= idx_s1;
			end else if (slot_rd_dist_q > acc_max_q) begin
				acc_max_q <= slot_rd_dist_q;
			end
		end
		if (emit_load) begin
			out_id_q   <= slot_rd_id_q;
			out_dist_q <= slot_rd_dist_q;
			out_last_q <= emit_last;
		end
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign neighbor_id       = out_id_q;
	assign neighbor_distance = out_dist_q;
	assign last_neighbor     = out_last_q;

	`KNN_ASSERT_ALWAYS(a_pos_range, clk, arst_n, pos_q < PW'(MAX_FEATURES), "position out of range")
	`KNN_ASSERT_SAME(a_scan_found, clk, arst_n, scan_end, found_q, "no slot at the maximum")
	`KNN_ASSERT_NEXT(a_append_fill, clk, arst_n, append, fill_q == $past(fill_q) + NW'(1), "fill did not advance")
	`KNN_ASSERT_NEXT(a_emit_clear, clk, arst_n, emit_load && emit_last, (fill_q == '0) && (max_q == '0), "table not cleared")

endmodule
